[rtl/rc_pulse_to_led_dimmer_unit_defines.svh]
// Assertion macros used by the dimmer top module.
`ifndef RC_PULSE_TO_LED_DIMMER_UNIT_DEFINES_SVH
`define RC_PULSE_TO_LED_DIMMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RCD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcd: assertion failed");

// Next-cycle implication, disabled during reset
`define RCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcd: assertion failed");

`endif

[rtl/rcd_pkg.sv]
package rcd_pkg;

  // widths
  localparam int PULSE_BITS_DEF = 12;
  localparam int THR_W          = 12;
  localparam int DUTY_W         = 8;
  localparam int HUE_W          = 9;
  localparam int OUT_W          = 48;
  localparam int RESULT_W       = 5 * DUTY_W + 2 + 1;
  localparam int OUT_PAD_W      = OUT_W - RESULT_W;

  localparam logic [THR_W-1:0] THR_RESET = 12'd1500;

  // target decode: (p - 1000) * 3 / 1000 reaches 1 at 1334 and 2 at 1667
  localparam int TARGET_1_MIN = 1334;
  localparam int TARGET_2_MIN = 1667;

  // brightness curve input window
  localparam int LEVEL_BASE    = 1000;
  localparam int LEVEL_TOP     = 2000;
  localparam int LEVEL_MAX_K   = 1000;
  localparam int LEVEL_MIN     = 40;
  localparam int LEVEL_SPAN    = 215;
  localparam int LEVEL_ROM_DEPTH = 1001;
  localparam int LEVEL_ADDR_W  = 10;

  // hue input window: (p - 1200) * 9 / 20, saturating at 360 which wraps to 0
  localparam int HUE_BASE   = 1200;
  localparam int HUE_TOP    = 2000;
  localparam int HUE_OFF_W  = 10;
  // x / 5 == (x * 3277) >> 14 for x below 1800
  localparam int DIV5_MUL   = 3277;
  localparam int DIV5_SHIFT = 14;
  localparam int SECTOR     = 60;

  typedef enum logic [1:0] {
    TGT_RGB  = 2'd0,
    TGT_LED1 = 2'd1,
    TGT_LED2 = 2'd2
  } target_t;

  // decoded item leaving the front stage
  typedef struct packed {
    logic              on;
    target_t           target;
    logic [DUTY_W-1:0] bright;
    logic [HUE_W-1:0]  hue;
  } dec_t;

  // unscaled color leaving the color stage
  typedef struct packed {
    logic              on;
    target_t           target;
    logic [DUTY_W-1:0] bright;
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } color_t;

  // result item, red in the low byte
  typedef struct packed {
    logic              power_on;
    target_t           chosen_target;
    logic [DUTY_W-1:0] second_led_duty;
    logic [DUTY_W-1:0] first_led_duty;
    logic [DUTY_W-1:0] blue_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] red_duty;
  } result_t;

  typedef logic [DUTY_W-1:0] level_rom_t [LEVEL_ROM_DEPTH];

  // y <= 215 * (k/1000)^1.2  <=>  y^5 * 2^18 * 5^13 <= 43^5 * k^6
  function automatic logic level_fits(int unsigned y, int unsigned k);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = 128'd1;
    rhs = 128'd147008443;
    for (int i = 0; i < 5; i++) lhs = lhs * 128'(y);
    lhs = lhs * 128'd262144;
    lhs = lhs * 128'd1220703125;
    for (int i = 0; i < 6; i++) rhs = rhs * 128'(k);
    return lhs <= rhs;
  endfunction

  // gamma-1.2 brightness table, evaluated at elaboration
  function automatic level_rom_t build_level_rom();
    level_rom_t  rom;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    for (int k = 0; k < LEVEL_ROM_DEPTH; k++) begin
      lo = 0;
      hi = LEVEL_SPAN;
      for (int s = 0; s < 8; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (level_fits(mid, k)) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
      end
      rom[k] = DUTY_W'(LEVEL_MIN + lo);
    end
    return rom;
  endfunction

endpackage

[rtl/rcd_front.sv]
module rcd_front #(
  parameter int PULSE_BITS = rcd_pkg::PULSE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rcd_pkg::THR_W-1:0]  power_threshold,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [PULSE_BITS-1:0]      target_pulse,
  input  logic [PULSE_BITS-1:0]      level_pulse,
  input  logic [PULSE_BITS-1:0]      hue_pulse,
  input  logic [PULSE_BITS-1:0]      power_pulse,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rcd_pkg::dec_t              out_item
);

  localparam int CMP_W = (PULSE_BITS > rcd_pkg::THR_W) ? PULSE_BITS : rcd_pkg::THR_W;
  localparam logic [PULSE_BITS-1:0] TGT1_MIN   = PULSE_BITS'(rcd_pkg::TARGET_1_MIN);
  localparam logic [PULSE_BITS-1:0] TGT2_MIN   = PULSE_BITS'(rcd_pkg::TARGET_2_MIN);
  localparam logic [PULSE_BITS-1:0] LVL_BASE   = PULSE_BITS'(rcd_pkg::LEVEL_BASE);
  localparam logic [PULSE_BITS-1:0] LVL_TOP    = PULSE_BITS'(rcd_pkg::LEVEL_TOP);
  localparam logic [PULSE_BITS-1:0] HUE_BASE_P = PULSE_BITS'(rcd_pkg::HUE_BASE);
  localparam logic [PULSE_BITS-1:0] HUE_TOP_P  = PULSE_BITS'(rcd_pkg::HUE_TOP);
  localparam rcd_pkg::level_rom_t LEVEL_ROM = rcd_pkg::build_level_rom();

  // input register
  logic                  valid0;
  logic [PULSE_BITS-1:0] tp;
  logic [PULSE_BITS-1:0] lp;
  logic [PULSE_BITS-1:0] hp;
  logic [PULSE_BITS-1:0] pp;

  logic                                  ready1;
  rcd_pkg::target_t                      target_next;
  logic                                  on_next;
  logic [rcd_pkg::LEVEL_ADDR_W-1:0]      level_addr;
  logic [PULSE_BITS-1:0]                 lp_off;
  logic [PULSE_BITS-1:0]                 hp_off;
  logic [rcd_pkg::HUE_OFF_W-1:0]         hue_off;
  logic [rcd_pkg::HUE_OFF_W+3:0]         hue_x9;
  logic [rcd_pkg::HUE_OFF_W+1:0]         hue_q4;
  logic [23:0]                           hue_prod;
  logic [rcd_pkg::HUE_W-1:0]             hue_next;

  assign ready1   = !out_valid || out_ready;
  assign in_ready = !valid0 || ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else if (in_ready) begin
      valid0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tp <= target_pulse;
      lp <= level_pulse;
      hp <= hue_pulse;
      pp <= power_pulse;
    end
  end

  // target select by threshold compares
  always_comb begin
    if (tp >= TGT2_MIN) begin
      target_next = rcd_pkg::TGT_LED2;
    end else if (tp >= TGT1_MIN) begin
      target_next = rcd_pkg::TGT_LED1;
    end else begin
      target_next = rcd_pkg::TGT_RGB;
    end
  end

  assign on_next = CMP_W'(pp) > CMP_W'(power_threshold);

  // brightness table address, clamped to 0..1000
  assign lp_off = lp - LVL_BASE;
  always_comb begin
    if (lp < LVL_BASE) begin
      level_addr = '0;
    end else if (lp >= LVL_TOP) begin
      level_addr = rcd_pkg::LEVEL_ADDR_W'(rcd_pkg::LEVEL_MAX_K);
    end else begin
      level_addr = lp_off[rcd_pkg::LEVEL_ADDR_W-1:0];
    end
  end

  // hue = off * 9 / 20 = ((off * 9) >> 2) / 5; 360 and above wrap to 0
  assign hp_off   = hp - HUE_BASE_P;
  assign hue_off  = hp_off[rcd_pkg::HUE_OFF_W-1:0];
  assign hue_x9   = (rcd_pkg::HUE_OFF_W+4)'({hue_off, 3'b000}) +
                    (rcd_pkg::HUE_OFF_W+4)'(hue_off);
  assign hue_q4   = hue_x9[rcd_pkg::HUE_OFF_W+3:2];
  assign hue_prod = 24'(hue_q4) * 24'(rcd_pkg::DIV5_MUL);

  always_comb begin
    if (hp < HUE_BASE_P || hp >= HUE_TOP_P) begin
      hue_next = '0;
    end else begin
      hue_next = hue_prod[rcd_pkg::DIV5_SHIFT +: rcd_pkg::HUE_W];
    end
  end

  // decode register with registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready1) begin
      out_valid <= valid0;
    end
  end

  always_ff @(posedge clk) begin
    if (valid0 && ready1) begin
      out_item.on     <= on_next;
      out_item.target <= target_next;
      out_item.hue    <= hue_next;
      out_item.bright <= LEVEL_ROM[level_addr];
    end
  end

endmodule

[rtl/rcd_color.sv]
module rcd_color (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rcd_pkg::dec_t   in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output rcd_pkg::color_t out_item
);

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  localparam logic [rcd_pkg::HUE_W-1:0] S1 = rcd_pkg::HUE_W'(rcd_pkg::SECTOR);
  localparam logic [rcd_pkg::HUE_W-1:0] S2 = rcd_pkg::HUE_W'(2 * rcd_pkg::SECTOR);
  localparam logic [rcd_pkg::HUE_W-1:0] S3 = rcd_pkg::HUE_W'(3 * rcd_pkg::SECTOR);
  localparam logic [rcd_pkg::HUE_W-1:0] S4 = rcd_pkg::HUE_W'(4 * rcd_pkg::SECTOR);
  localparam logic [rcd_pkg::HUE_W-1:0] S5 = rcd_pkg::HUE_W'(5 * rcd_pkg::SECTOR);
  localparam logic [6:0] SEC_LEN = 7'(rcd_pkg::SECTOR);
  localparam logic [rcd_pkg::DUTY_W-1:0] FULL = '1;

  sector_t                    sector;
  logic [rcd_pkg::HUE_W-1:0]  hue_rel;
  logic [6:0]                 ramp;
  logic [10:0]                ramp_x17;
  logic [rcd_pkg::DUTY_W-1:0] ramp_val;
  logic [rcd_pkg::DUTY_W-1:0] red_next;
  logic [rcd_pkg::DUTY_W-1:0] green_next;
  logic [rcd_pkg::DUTY_W-1:0] blue_next;

  assign in_ready = !out_valid || out_ready;

  // sector and offset inside it
  always_comb begin
    if (in_item.hue < S1) begin
      sector  = SEC_RED_YEL;
      hue_rel = in_item.hue;
    end else if (in_item.hue < S2) begin
      sector  = SEC_YEL_GRN;
      hue_rel = in_item.hue - S1;
    end else if (in_item.hue < S3) begin
      sector  = SEC_GRN_CYN;
      hue_rel = in_item.hue - S2;
    end else if (in_item.hue < S4) begin
      sector  = SEC_CYN_BLU;
      hue_rel = in_item.hue - S3;
    end else if (in_item.hue < S5) begin
      sector  = SEC_BLU_MAG;
      hue_rel = in_item.hue - S4;
    end else begin
      sector  = SEC_MAG_RED;
      hue_rel = in_item.hue - S5;
    end
  end

  // ramp rises in even sectors, falls in odd ones; 255*u/60 rounded half up
  assign ramp     = sector[0] ? (SEC_LEN - hue_rel[6:0]) : hue_rel[6:0];
  assign ramp_x17 = {ramp, 4'b0000} + 11'(ramp) + 11'd2;
  assign ramp_val = ramp_x17[9:2];

  always_comb begin
    case (sector)
      SEC_RED_YEL: begin
        red_next = FULL;     green_next = ramp_val; blue_next = '0;
      end
      SEC_YEL_GRN: begin
        red_next = ramp_val; green_next = FULL;     blue_next = '0;
      end
      SEC_GRN_CYN: begin
        red_next = '0;       green_next = FULL;     blue_next = ramp_val;
      end
      SEC_CYN_BLU: begin
        red_next = '0;       green_next = ramp_val; blue_next = FULL;
      end
      SEC_BLU_MAG: begin
        red_next = ramp_val; green_next = '0;       blue_next = FULL;
      end
      SEC_MAG_RED: begin
        red_next = FULL;     green_next = '0;       blue_next = ramp_val;
      end
      default: begin
        red_next = '0;       green_next = '0;       blue_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item.on     <= in_item.on;
      out_item.target <= in_item.target;
      out_item.bright <= in_item.bright;
      out_item.red    <= red_next;
      out_item.green  <= green_next;
      out_item.blue   <= blue_next;
    end
  end

endmodule

[rtl/rcd_mix.sv]
module rcd_mix (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rcd_pkg::color_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output rcd_pkg::result_t out_item
);

  localparam int DW = rcd_pkg::DUTY_W;

  // c * b / 255 exactly for 8-bit c and b
  function automatic logic [DW-1:0] scale(logic [DW-1:0] c, logic [DW-1:0] b);
    logic [2*DW-1:0] prod;
    logic [2*DW:0]   adj;
    prod = (2*DW)'(c) * (2*DW)'(b);
    adj  = (2*DW+1)'(prod) + (2*DW+1)'(prod[2*DW-1:DW]) + (2*DW+1)'(1);
    return adj[2*DW-1:DW];
  endfunction

  // held duty levels
  logic [DW-1:0] red_level;
  logic [DW-1:0] green_level;
  logic [DW-1:0] blue_level;
  logic [DW-1:0] first_led_level;
  logic [DW-1:0] second_led_level;

  logic [DW-1:0] red_level_next;
  logic [DW-1:0] green_level_next;
  logic [DW-1:0] blue_level_next;
  logic [DW-1:0] first_led_level_next;
  logic [DW-1:0] second_led_level_next;
  logic          load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // update only the levels of the chosen target
  always_comb begin
    red_level_next        = red_level;
    green_level_next      = green_level;
    blue_level_next       = blue_level;
    first_led_level_next  = first_led_level;
    second_led_level_next = second_led_level;
    case (in_item.target)
      rcd_pkg::TGT_RGB: begin
        red_level_next   = scale(in_item.red, in_item.bright);
        green_level_next = scale(in_item.green, in_item.bright);
        blue_level_next  = scale(in_item.blue, in_item.bright);
      end
      rcd_pkg::TGT_LED1: first_led_level_next = in_item.bright;
      rcd_pkg::TGT_LED2: second_led_level_next = in_item.bright;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      red_level        <= '0;
      green_level      <= '0;
      blue_level       <= '0;
      first_led_level  <= '0;
      second_led_level <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        red_level        <= red_level_next;
        green_level      <= green_level_next;
        blue_level       <= blue_level_next;
        first_led_level  <= first_led_level_next;
        second_led_level <= second_led_level_next;
      end
    end
  end

  // result register, duties gated by power
  always_ff @(posedge clk) begin
    if (load) begin
      out_item.power_on        <= in_item.on;
      out_item.chosen_target   <= in_item.target;
      out_item.red_duty        <= in_item.on ? red_level_next : '0;
      out_item.green_duty      <= in_item.on ? green_level_next : '0;
      out_item.blue_duty       <= in_item.on ? blue_level_next : '0;
      out_item.first_led_duty  <= in_item.on ? first_led_level_next : '0;
      out_item.second_led_duty <= in_item.on ? second_led_level_next : '0;
    end
  end

endmodule

[rtl/rc_pulse_to_led_dimmer_unit.sv]
// RC pulse to LED dimmer: each item carries four measured pulse widths and
// yields one item with five PWM duties, the chosen target and the power flag.
// It takes one item per clock unless the output stalls, through the input
// register, decode with a registered read of the 1001-entry gamma brightness
// table, hue-to-color stage, and scaling stage that updates the held levels
// and loads the output register. Each stage moves on when the one after it
// is empty or moving, so an item can enter while a finished result waits.
// The user must write the power threshold through cfg_we/cfg_wdata only
// while the block is idle, which it does not enforce. Reset sets it to 1500.
`include "rc_pulse_to_led_dimmer_unit_defines.svh"

module rc_pulse_to_led_dimmer_unit #(
  parameter int PULSE_BITS = rcd_pkg::PULSE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rcd_pkg::THR_W-1:0]        cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // target_pulse, level_pulse, hue_pulse, power_pulse (PULSE_BITS each), zero pad
  input  logic [((4*PULSE_BITS+7)/8)*8-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // red_duty, green_duty, blue_duty, first_led_duty, second_led_duty (8 each),
  // chosen_target (2), power_on (1), zero pad
  output logic [rcd_pkg::OUT_W-1:0]        m_tdata
);

  localparam logic [rcd_pkg::DUTY_W-1:0] LED_FLOOR = rcd_pkg::DUTY_W'(rcd_pkg::LEVEL_MIN);

  logic [rcd_pkg::THR_W-1:0] power_threshold;
  logic                      dec_valid;
  logic                      dec_ready;
  rcd_pkg::dec_t             dec_item;
  logic                      color_valid;
  logic                      color_ready;
  rcd_pkg::color_t           color_item;
  rcd_pkg::result_t          res;
  logic                      duties_zero;
  logic                      led1_shown;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      power_threshold <= rcd_pkg::THR_RESET;
    end else if (cfg_we) begin
      power_threshold <= cfg_wdata;
    end
  end

  rcd_front #(
    .PULSE_BITS (PULSE_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .power_threshold (power_threshold),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .target_pulse    (s_tdata[PULSE_BITS-1:0]),
    .level_pulse     (s_tdata[2*PULSE_BITS-1:PULSE_BITS]),
    .hue_pulse       (s_tdata[3*PULSE_BITS-1:2*PULSE_BITS]),
    .power_pulse     (s_tdata[4*PULSE_BITS-1:3*PULSE_BITS]),
    .out_valid       (dec_valid),
    .out_ready       (dec_ready),
    .out_item        (dec_item)
  );

  rcd_color u_color (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_item   (dec_item),
    .out_valid (color_valid),
    .out_ready (color_ready),
    .out_item  (color_item)
  );

  rcd_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (color_valid),
    .in_ready  (color_ready),
    .in_item   (color_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (res)
  );

  assign m_tdata = {{rcd_pkg::OUT_PAD_W{1'b0}}, res};

  // checks
  assign duties_zero = res.red_duty == '0 && res.green_duty == '0 && res.blue_duty == '0 &&
                       res.first_led_duty == '0 && res.second_led_duty == '0;
  assign led1_shown  = m_tvalid && res.power_on && res.chosen_target == rcd_pkg::TGT_LED1;

  `RCD_ASSERT_IMPL(a_off_zero, clk, rst, m_tvalid && !res.power_on, duties_zero)
  `RCD_ASSERT_IMPL(a_led1_floor, clk, rst, led1_shown, res.first_led_duty >= LED_FLOOR)
  `RCD_ASSERT_IMPL(a_empty_ready, clk, rst, !m_tvalid, s_tready)
  `RCD_ASSERT_NEXT(a_no_extra, clk, rst, m_tvalid && m_tready && !color_valid, !m_tvalid)

endmodule
